>>> hw/rtl/fhpc_pkg.sv
// Shared constants for the image-header platform classifier:
// signature table, platform and word-scan codes, counter sizing.
// No dependencies.
package fhpc_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int COUNT_W   = $clog2(MAX_BYTES + 1);
    localparam int MIN_LEN   = 512;
    localparam int SCAN_LEN  = 1024;

    localparam int VIEW_BYTES = 10;
    localparam int WIN_W      = 72;
    localparam int VIEW_W     = 80;
    localparam int NUM_CLASS  = 9;
    localparam int NUM_SIGS   = 41;

    // platform codes
    localparam logic [2:0] PLAT_UNKNOWN = 3'd0;
    localparam logic [2:0] PLAT_MTK     = 3'd1;
    localparam logic [2:0] PLAT_SPD     = 3'd2;
    localparam logic [2:0] PLAT_EXN     = 3'd3;
    localparam logic [2:0] PLAT_QCM     = 3'd4;
    localparam logic [2:0] PLAT_KRN     = 3'd5;
    localparam logic [2:0] PLAT_SAM     = 3'd6;

    // aligned word scan verdicts
    localparam logic [1:0] WORD_NONE = 2'd0;
    localparam logic [1:0] WORD_MTK  = 2'd1;
    localparam logic [1:0] WORD_QCM  = 2'd2;

    localparam logic [31:0] WORD_MMMM = 32'h4d4d4d4d;
    localparam logic [31:0] WORD_QIMG = 32'h51494d47;
    localparam logic [31:0] WORD_QCLO = 32'h51434c4f;

    // class index -> platform code, lowest index has priority
    localparam logic [2:0] CLASS_CODE [NUM_CLASS] = '{
        PLAT_MTK, PLAT_SPD, PLAT_EXN, PLAT_QCM, PLAT_KRN,
        PLAT_SPD, PLAT_SAM, PLAT_QCM, PLAT_UNKNOWN
    };

    // signature bytes, oldest byte in the most significant used position
    localparam logic [79:0] SIG_VALUE [NUM_SIGS] = '{
        80'h4d544b,
        80'h4d656469_6174656b,
        80'h4d656469_6154656b,
        80'h88888888,
        80'hcececece,
        80'h4d544d4d,
        80'h4b544d,
        80'h53505244,
        80'h7370_72656164_7472756d,
        80'h5370_72656164_7472756d,
        80'h4558_594e4f53,
        80'h6578_796e6f73,
        80'h4578_796e6f73,
        80'h51435f49_4d414745,
        80'h5155414c_434f4d4d,
        80'h7175616c_636f6d6d,
        80'h4d534d,
        80'h53444d,
        80'h71636f6d,
        80'h51434f4d,
        80'h4b_4952494e,
        80'h6b_6972696e,
        80'h4b_6972696e,
        80'h48493336,
        80'h48493632,
        80'h68693336,
        80'h68693632,
        80'h554e_49534f43,
        80'h756e_69736f63,
        80'h556e_69736f63,
        80'h53414d_53554e47,
        80'h73616d_73756e67,
        80'h5345435f,
        80'h474f_4f474c45,
        80'h676f_6f676c65,
        80'h50_6978656c,
        80'h70_6978656c,
        80'h5849_414f4d49,
        80'h7869_616f6d69,
        80'h52_65646d69,
        80'h72_65646d69
    };

    localparam logic [3:0] SIG_LEN [NUM_SIGS] = '{
        4'd3, 4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd3,
        4'd4, 4'd10, 4'd10,
        4'd6, 4'd6, 4'd6,
        4'd8, 4'd8, 4'd8, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd6, 4'd6, 4'd6,
        4'd7, 4'd7, 4'd4,
        4'd6, 4'd6, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd5, 4'd5
    };

    localparam logic [3:0] SIG_CLASS [NUM_SIGS] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd1, 4'd1, 4'd1,
        4'd2, 4'd2, 4'd2,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd6,
        4'd7, 4'd7, 4'd7, 4'd7,
        4'd8, 4'd8, 4'd8, 4'd8
    };

endpackage

>>> hw/rtl/fhpc_byte_if.sv
// Header byte channel: valid/ready handshake with one byte and a last mark.
// No dependencies.
interface fhpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/fhpc_code_if.sv
// Result channel: valid/ready handshake carrying one platform code.
// No dependencies.
interface fhpc_code_if;
    logic       valid;
    logic       ready;
    logic [2:0] platform_code;

    modport source (output valid, output platform_code, input ready);
    modport sink   (input valid, input platform_code, output ready);
endinterface

>>> hw/rtl/fhpc_matcher.sv
// Signature matcher: compares the tail of a ten-byte view against the
// signature table and checks the newest four bytes as an aligned word.
// Depends on fhpc_pkg.
module fhpc_matcher (
    input  logic [79:0] view,
    output logic [8:0]  hits,
    output logic [1:0]  word_code
);

    // low len bytes of the view equal the low len bytes of the pattern
    function automatic logic tail_match(input logic [79:0] v, input logic [79:0] pat,
                                        input logic [3:0] len);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < fhpc_pkg::VIEW_BYTES; i++)
        begin
            if (4'(i) < len && v[i*8 +: 8] != pat[i*8 +: 8])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb
    begin
        hits = '0;
        for (int s = 0; s < fhpc_pkg::NUM_SIGS; s++)
        begin
            if (tail_match(view, fhpc_pkg::SIG_VALUE[s], fhpc_pkg::SIG_LEN[s]))
            begin
                hits[fhpc_pkg::SIG_CLASS[s]] = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (view[31:0] == fhpc_pkg::WORD_MMMM)
        begin
            word_code = fhpc_pkg::WORD_MTK;
        end
        else if (view[31:0] == fhpc_pkg::WORD_QIMG || view[31:0] == fhpc_pkg::WORD_QCLO)
        begin
            word_code = fhpc_pkg::WORD_QCM;
        end
        else
        begin
            word_code = fhpc_pkg::WORD_NONE;
        end
    end

endmodule

>>> hw/rtl/firmware_header_platform_classifier.sv
// Image-header platform classifier, top level.
// Depends on fhpc_pkg, fhpc_byte_if, fhpc_code_if and fhpc_matcher.
//
// Usage:
//   hdr     sink of header bytes in file order; last_byte marks the final one.
//   verdict source of one platform_code per header, sent after the last byte.
// A transaction on hdr is registered, then matched against the signature
// table and folded into the hit flags, byte count and word-scan verdict.
// One byte is taken every cycle while hdr.ready is high; the code for a
// header is registered as its last byte is processed and holds until taken.
// Bytes beyond MAX_BYTES are dropped but their last mark still ends the
// header. After each result all header state returns to zero.
// Reset (rst_n low) empties the input and output registers and clears all
// header state. While a code waits on verdict, bytes that do not end a
// header still flow; a second last byte waits in the input register, and
// hdr.ready drops only then.
module firmware_header_platform_classifier (
    input  logic              clk,
    input  logic              rst_n,
    fhpc_byte_if.sink         hdr,
    fhpc_code_if.source       verdict
);

    localparam int CW = fhpc_pkg::COUNT_W;

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_last_reg;
    logic [fhpc_pkg::WIN_W-1:0] window_reg;
    logic [8:0]                 hits_reg;
    logic [CW-1:0]              count_reg;
    logic [1:0]                 word_reg;
    logic                       out_valid_reg;
    logic [2:0]                 out_code_reg;

    logic [fhpc_pkg::VIEW_W-1:0] view;
    logic [8:0]                  match_hits;
    logic [1:0]                  match_word;
    logic                        advance;
    logic                        process;
    logic                        take;
    logic [8:0]                  hits_next;
    logic [CW-1:0]               count_next;
    logic [1:0]                  word_next;
    logic [2:0]                  code_next;

    assign advance = !s1_valid_reg || !s1_last_reg || !out_valid_reg || verdict.ready;
    assign hdr.ready = advance;
    assign process = s1_valid_reg && advance;
    assign take = process && (count_reg < CW'(fhpc_pkg::MAX_BYTES));

    assign view = {window_reg, s1_byte_reg};

    fhpc_matcher u_matcher (
        .view      (view),
        .hits      (match_hits),
        .word_code (match_word)
    );

    always_comb
    begin
        hits_next  = hits_reg;
        count_next = count_reg;
        word_next  = word_reg;
        if (take)
        begin
            hits_next  = hits_reg | match_hits;
            count_next = count_reg + CW'(1);
            if (count_next <= CW'(fhpc_pkg::SCAN_LEN) && count_next[1:0] == 2'b00
                && word_reg == fhpc_pkg::WORD_NONE)
            begin
                word_next = match_word;
            end
        end
    end

    always_comb
    begin
        code_next = fhpc_pkg::PLAT_UNKNOWN;
        if (count_next >= CW'(fhpc_pkg::MIN_LEN))
        begin
            if (hits_next != '0)
            begin
                for (int c = fhpc_pkg::NUM_CLASS - 1; c >= 0; c--)
                begin
                    if (hits_next[c])
                    begin
                        code_next = fhpc_pkg::CLASS_CODE[c];
                    end
                end
            end
            else if (count_next >= CW'(fhpc_pkg::SCAN_LEN))
            begin
                case (word_next)
                    fhpc_pkg::WORD_MTK: code_next = fhpc_pkg::PLAT_MTK;
                    fhpc_pkg::WORD_QCM: code_next = fhpc_pkg::PLAT_QCM;
                    default:            code_next = fhpc_pkg::PLAT_UNKNOWN;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            window_reg    <= '0;
            hits_reg      <= '0;
            count_reg     <= '0;
            word_reg      <= fhpc_pkg::WORD_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= hdr.valid;
            end
            if (process && s1_last_reg)
            begin
                // header done: emit and start over
                out_valid_reg <= 1'b1;
                window_reg    <= '0;
                hits_reg      <= '0;
                count_reg     <= '0;
                word_reg      <= fhpc_pkg::WORD_NONE;
            end
            else
            begin
                if (verdict.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (take)
                begin
                    window_reg <= view[fhpc_pkg::WIN_W-1:0];
                end
                hits_reg  <= hits_next;
                count_reg <= count_next;
                word_reg  <= word_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hdr.valid)
        begin
            s1_byte_reg <= hdr.data_byte;
            s1_last_reg <= hdr.last_byte;
        end
        if (process && s1_last_reg)
        begin
            out_code_reg <= code_next;
        end
    end

    assign verdict.valid         = out_valid_reg;
    assign verdict.platform_code = out_code_reg;

endmodule
